/* rtl/core/dstp_pkg.sv */
// Shared types and constants of the dual source time pairing table.
package dstp_pkg;

  // Number of pairing slots and the width of a slot number.
  localparam int Slots     = 16;
  localparam int SlotIdxW  = (Slots > 1) ? $clog2(Slots) : 1;

  // Depth of the request queue between the front and the back part.
  localparam int QDepth    = 2;
  localparam int QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam int TimeW     = 32;
  localparam int KeyW      = TimeW - 1;
  localparam int RollW     = 32;
  localparam int PayloadW  = 64;
  localparam int WindowW   = 20;
  localparam int StatusW   = 2;
  localparam int OutIdxW   = 4;

  localparam logic [WindowW-1:0] WindowReset = WindowW'(10000);

  typedef enum logic [StatusW-1:0] {
    STATUS_PAIRED  = 2'd0,
    STATUS_STORED  = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_NO_TIME = 2'd3
  } status_e;

  // A classified request as it leaves the front part.
  typedef struct packed {
    logic                no_time;
    logic                is_main;
    logic [KeyW-1:0]     key;
    logic [TimeW-1:0]    main_time;
    logic [TimeW-1:0]    sub_time;
    logic [RollW-1:0]    roll;
    logic [PayloadW-1:0] payload;
  } item_t;

  // Package data kept in a slot.
  typedef struct packed {
    logic [TimeW-1:0]    main_time;
    logic [TimeW-1:0]    sub_time;
    logic [RollW-1:0]    roll;
    logic [PayloadW-1:0] payload;
  } slot_data_t;

endpackage

/* rtl/core/dstp_front.sv */
// Front part: takes requests, classifies them and queues them for the back part.
module dstp_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic signed [dstp_pkg::TimeW-1:0]  main_time_i,
  input  logic signed [dstp_pkg::TimeW-1:0]  sub_time_i,
  input  logic [dstp_pkg::RollW-1:0]         roll_word_i,
  input  logic [dstp_pkg::PayloadW-1:0]      payload_i,
  output logic                               q_valid_o,
  input  logic                               q_ready_i,
  output dstp_pkg::item_t                    q_item_o
);

  dstp_pkg::item_t                 fifo_q [dstp_pkg::QDepth];
  logic [dstp_pkg::QPtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [dstp_pkg::QCntW-1:0]      cnt_q, cnt_d;
  dstp_pkg::item_t                 item;
  logic                            do_push, do_pop;

  // A request is main when its main time is present, else sub when its sub time is.
  always_comb begin
    item.no_time   = main_time_i[dstp_pkg::TimeW-1] & sub_time_i[dstp_pkg::TimeW-1];
    item.is_main   = ~main_time_i[dstp_pkg::TimeW-1];
    item.key       = item.is_main ? main_time_i[dstp_pkg::KeyW-1:0]
                                  : sub_time_i[dstp_pkg::KeyW-1:0];
    item.main_time = main_time_i;
    item.sub_time  = sub_time_i;
    item.roll      = roll_word_i;
    item.payload   = payload_i;
  end

  assign full      = (cnt_q == dstp_pkg::QCntW'(dstp_pkg::QDepth));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = fifo_q[rd_q];
  assign do_push   = push & ~full;
  assign do_pop    = q_ready_i & q_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == dstp_pkg::QPtrW'(dstp_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == dstp_pkg::QPtrW'(dstp_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_q] <= item;
    end
  end

endmodule

/* rtl/core/dstp_back.sv */
// Back part: slot table search, slot update, merge and the result register.
module dstp_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dstp_pkg::WindowW-1:0]        cfg_wdata_i,
  input  logic                                q_valid_i,
  output logic                                q_ready_o,
  input  dstp_pkg::item_t                     q_item_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [dstp_pkg::StatusW-1:0]        status_o,
  output logic [dstp_pkg::OutIdxW-1:0]        slot_index_o,
  output logic signed [dstp_pkg::TimeW-1:0]   out_main_time_o,
  output logic signed [dstp_pkg::TimeW-1:0]   out_sub_time_o,
  output logic [dstp_pkg::RollW-1:0]          out_roll_o,
  output logic [dstp_pkg::PayloadW-1:0]       out_payload_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_PICK,
    S_READ
  } state_e;

  localparam int IdxW = dstp_pkg::SlotIdxW;
  localparam int SumW = dstp_pkg::KeyW + 1;

  state_e                            state_q;
  logic [dstp_pkg::WindowW-1:0]      window_q;
  dstp_pkg::item_t                   cur_q;
  logic [dstp_pkg::Slots-1:0]        busy_q, wants_sub_q, hit_q, hit_d;
  logic [dstp_pkg::KeyW-1:0]         key_q [dstp_pkg::Slots];
  dstp_pkg::slot_data_t              mem_q [dstp_pkg::Slots];
  dstp_pkg::slot_data_t              rd_q;
  logic [IdxW-1:0]                   sel_q;

  logic                              out_valid_q;
  dstp_pkg::status_e                 status_q;
  logic [dstp_pkg::OutIdxW-1:0]      index_q;
  logic [dstp_pkg::TimeW-1:0]        main_q, sub_q;
  logic [dstp_pkg::RollW-1:0]        roll_q;
  logic [dstp_pkg::PayloadW-1:0]     pay_q;

  logic [IdxW-1:0]                   hit_idx, free_idx;
  logic                              hit_any, free_any;
  logic [SumW-1:0]                   win_ext;
  logic                              take, mem_we, mem_re;
  logic [IdxW+dstp_pkg::OutIdxW-1:0] free_ext, sel_ext;

  assign q_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign take      = q_ready_o & q_valid_i;
  assign win_ext   = SumW'(window_q);

  // Window test per slot: both keys are non-negative, so |a - b| <= w
  // is a <= b + w and b <= a + w.
  always_comb begin
    for (int i = 0; i < dstp_pkg::Slots; i++) begin
      hit_d[i] = busy_q[i] && (wants_sub_q[i] != cur_q.is_main) &&
                 ({1'b0, cur_q.key} <= ({1'b0, key_q[i]} + win_ext)) &&
                 ({1'b0, key_q[i]} <= ({1'b0, cur_q.key} + win_ext));
    end
  end

  // Lowest numbered matching slot and lowest numbered free slot.
  always_comb begin
    hit_idx  = '0;
    hit_any  = 1'b0;
    free_idx = '0;
    free_any = 1'b0;
    for (int i = dstp_pkg::Slots - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_idx = IdxW'(i);
        hit_any = 1'b1;
      end
      if (!busy_q[i]) begin
        free_idx = IdxW'(i);
        free_any = 1'b1;
      end
    end
  end

  // The matched slot number is kept for the merge cycle.
  assign sel_ext  = {{dstp_pkg::OutIdxW{1'b0}}, sel_q};
  assign free_ext = {{dstp_pkg::OutIdxW{1'b0}}, free_idx};
  assign mem_re   = (state_q == S_PICK) && !cur_q.no_time && hit_any;
  assign mem_we   = (state_q == S_PICK) && !cur_q.no_time && !hit_any && free_any;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= dstp_pkg::WindowReset;
      cur_q       <= '0;
      hit_q       <= '0;
      busy_q      <= '0;
      wants_sub_q <= '0;
      sel_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= dstp_pkg::STATUS_PAIRED;
      index_q     <= '0;
      main_q      <= '0;
      sub_q       <= '0;
      roll_q      <= '0;
      pay_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (take) begin
            cur_q   <= q_item_i;
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          hit_q   <= hit_d;
          state_q <= S_PICK;
        end
        S_PICK: begin
          main_q <= '0;
          sub_q  <= '0;
          roll_q <= '0;
          pay_q  <= '0;
          if (cur_q.no_time) begin
            status_q    <= dstp_pkg::STATUS_NO_TIME;
            index_q     <= '0;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (hit_any) begin
            busy_q[hit_idx] <= 1'b0;
            sel_q           <= hit_idx;
            state_q         <= S_READ;
          end else if (free_any) begin
            busy_q[free_idx]      <= 1'b1;
            wants_sub_q[free_idx] <= cur_q.is_main;
            status_q              <= dstp_pkg::STATUS_STORED;
            index_q               <= free_ext[dstp_pkg::OutIdxW-1:0];
            out_valid_q           <= 1'b1;
            state_q               <= S_IDLE;
          end else begin
            status_q    <= dstp_pkg::STATUS_FULL;
            index_q     <= '0;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_READ: begin
          status_q    <= dstp_pkg::STATUS_PAIRED;
          index_q     <= sel_ext[dstp_pkg::OutIdxW-1:0];
          out_valid_q <= 1'b1;
          if (cur_q.is_main) begin
            main_q <= cur_q.main_time;
            sub_q  <= rd_q.sub_time;
            roll_q <= rd_q.roll;
            pay_q  <= cur_q.payload;
          end else begin
            main_q <= rd_q.main_time;
            sub_q  <= cur_q.sub_time;
            roll_q <= cur_q.roll;
            pay_q  <= rd_q.payload;
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Slot keys and slot data; both are written only when a request is stored.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_q[free_idx] <= cur_q.key;
      mem_q[free_idx] <= '{main_time: cur_q.main_time, sub_time: cur_q.sub_time,
                           roll: cur_q.roll, payload: cur_q.payload};
    end
    if (mem_re) begin
      rd_q <= mem_q[hit_idx];
    end
  end

  assign empty           = ~out_valid_q;
  assign status_o        = status_q;
  assign slot_index_o    = index_q;
  assign out_main_time_o = main_q;
  assign out_sub_time_o  = sub_q;
  assign out_roll_o      = roll_q;
  assign out_payload_o   = pay_q;

endmodule

/* rtl/core/dual_source_time_pairing_table_top.sv */
// Top level of the dual source time pairing table.
//
// The block pairs packages from a main and a sub receiver by timestamp.
// Requests enter through a queue-like port: a request is taken at a rising
// edge where push is high and full is low. Results leave the same way: the
// oldest result stands on the result ports while empty is low and is taken
// at a rising edge where pop is high and empty is low. Every request gives
// exactly one result, in request order.
// The front part classifies each request as main, sub or without time and
// places it in a two-entry queue, so requests keep being taken while a
// result waits. The back part handles one request at a time, in steps:
// taking it, the window compare against all slots, picking the lowest
// matching or free slot and, on a pairing, reading the slot memory to
// merge the paired data. It takes the next request only when it is idle
// and its result register has been emptied. The match window is written
// through cfg_we_i and cfg_wdata_i; the user must write it only while the
// block is idle, as the block itself does not enforce this. Reset frees
// every slot, empties both queues and sets the window to 10000
// microseconds. When the receiver stalls, the result is held, the back
// part waits and the front queue fills until full rises.
module dual_source_time_pairing_table_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dstp_pkg::WindowW-1:0]        cfg_wdata_i,
  input  logic                                push,
  output logic                                full,
  input  logic signed [dstp_pkg::TimeW-1:0]   main_time_i,
  input  logic signed [dstp_pkg::TimeW-1:0]   sub_time_i,
  input  logic [dstp_pkg::RollW-1:0]          roll_word_i,
  input  logic [dstp_pkg::PayloadW-1:0]       payload_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [dstp_pkg::StatusW-1:0]        status_o,
  output logic [dstp_pkg::OutIdxW-1:0]        slot_index_o,
  output logic signed [dstp_pkg::TimeW-1:0]   out_main_time_o,
  output logic signed [dstp_pkg::TimeW-1:0]   out_sub_time_o,
  output logic [dstp_pkg::RollW-1:0]          out_roll_o,
  output logic [dstp_pkg::PayloadW-1:0]       out_payload_o
);

  // Classified requests between the front and the back part.
  logic            q_valid;
  logic            q_ready;
  dstp_pkg::item_t q_item;

  dstp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .main_time_i (main_time_i),
    .sub_time_i  (sub_time_i),
    .roll_word_i (roll_word_i),
    .payload_i   (payload_i),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_item_o    (q_item)
  );

  dstp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_valid_i       (q_valid),
    .q_ready_o       (q_ready),
    .q_item_i        (q_item),
    .empty           (empty),
    .pop             (pop),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .out_main_time_o (out_main_time_o),
    .out_sub_time_o  (out_sub_time_o),
    .out_roll_o      (out_roll_o),
    .out_payload_o   (out_payload_o)
  );

endmodule
